@@ sv/sde_pkg.sv @@
// shared types, constants and slot arithmetic for the searchable deque engine
`timescale 1ns / 1ps

package sde_pkg;

   // store geometry
   localparam int CAPACITY = 64;
   localparam int ADDR_W   = $clog2(CAPACITY);
   localparam int CNT_W    = $clog2(CAPACITY + 1);

   // field widths
   localparam int ACTION_W = 3;
   localparam int VALUE_W  = 64;
   localparam int POS_W    = 6;
   localparam int STATUS_W = 2;
   localparam int IDX_W    = 6;
   localparam int LEN_W    = 7;

   // packed stream widths, rounded up to whole bytes
   localparam int REQ_BITS = ACTION_W + VALUE_W + POS_W;
   localparam int REQ_W    = ((REQ_BITS + 7) / 8) * 8;
   localparam int RSP_BITS = STATUS_W + 3 * VALUE_W + IDX_W + LEN_W;
   localparam int RSP_W    = ((RSP_BITS + 7) / 8) * 8;

   typedef enum logic [ACTION_W-1:0] {
      ACT_PUSH_BACK  = 3'd0,
      ACT_PUSH_FRONT = 3'd1,
      ACT_POP_BACK   = 3'd2,
      ACT_POP_FRONT  = 3'd3,
      ACT_FIND       = 3'd4,
      ACT_READ_AT    = 3'd5,
      ACT_DELETE_AT  = 3'd6,
      ACT_QUERY      = 3'd7
   } action_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2,
      ST_MISS  = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_EXEC,
      S_FIND,
      S_READ,
      S_DEL,
      S_FRONT,
      S_BACK,
      S_BACK_CAP,
      S_DONE
   } state_type;

   // one result word handed from the sequencer to the output register
   typedef struct packed {
      status_type           status;
      logic [VALUE_W-1:0]   read_value;
      logic [IDX_W-1:0]     found_index;
      logic [LEN_W-1:0]     length;
      logic [VALUE_W-1:0]   front_value;
      logic [VALUE_W-1:0]   back_value;
   } result_type;

   // store slot of a position counted from the head, wrapping at capacity
   function automatic logic [ADDR_W-1:0] slot_of(input logic [ADDR_W-1:0] head,
                                                 input logic [ADDR_W-1:0] idx);
      logic [ADDR_W:0] sum;
      sum = {1'b0, head} + {1'b0, idx};
      if (sum >= (ADDR_W + 1)'(CAPACITY)) begin
         sum = sum - (ADDR_W + 1)'(CAPACITY);
      end
      return sum[ADDR_W-1:0];
   endfunction

endpackage

@@ sv/sde_ram.sv @@
// element store: one write port, one registered read port
`timescale 1ns / 1ps

module sde_ram
   import sde_pkg::*;
(
   input  logic               clock,
   input  logic               wr_en,
   input  logic [ADDR_W-1:0]  wr_addr,
   input  logic [VALUE_W-1:0] wr_data,
   input  logic               rd_en,
   input  logic [ADDR_W-1:0]  rd_addr,
   output logic [VALUE_W-1:0] rd_data
);

   logic [VALUE_W-1:0] mem_ff [CAPACITY];
   logic [VALUE_W-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ sv/sde_seq.sv @@
// operation sequencer: walks the store through one read port and one comparator
`timescale 1ns / 1ps

module sde_seq
   import sde_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               op_valid,
   input  action_type         op_action,
   input  logic [VALUE_W-1:0] op_value,
   input  logic [POS_W-1:0]   op_position,
   output logic               op_ready,
   output logic               res_valid,
   input  logic               res_take,
   output result_type         res_word
);

   state_type            state_ff, state_in;
   logic [ADDR_W-1:0]    head_ff, head_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   action_type           act_ff, act_in;
   logic [VALUE_W-1:0]   val_ff, val_in;
   logic [POS_W-1:0]     pos_ff, pos_in;
   logic [CNT_W-1:0]     ri_ff, ri_in;
   logic [ADDR_W-1:0]    wi_ff, wi_in;
   logic [ADDR_W-1:0]    cmp_idx_ff, cmp_idx_in;
   logic                 pend_ff, pend_in;
   status_type           status_ff, status_in;
   logic [VALUE_W-1:0]   rdval_ff, rdval_in;
   logic [ADDR_W-1:0]    fidx_ff, fidx_in;
   logic [VALUE_W-1:0]   front_ff, front_in;
   logic [VALUE_W-1:0]   back_ff, back_in;

   logic                 wr_en;
   logic [ADDR_W-1:0]    wr_addr;
   logic [VALUE_W-1:0]   wr_data;
   logic                 rd_en;
   logic [ADDR_W-1:0]    rd_addr;
   logic [VALUE_W-1:0]   rd_data;

   logic                 full;
   logic                 empty;
   logic                 pos_bad;
   logic [ADDR_W-1:0]    head_dec;
   logic [ADDR_W-1:0]    head_inc;
   logic                 hit;

   sde_ram u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         head_ff  <= '0;
         count_ff <= '0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         head_ff  <= head_in;
         count_ff <= count_in;
         pend_ff  <= pend_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      act_ff     <= act_in;
      val_ff     <= val_in;
      pos_ff     <= pos_in;
      ri_ff      <= ri_in;
      wi_ff      <= wi_in;
      cmp_idx_ff <= cmp_idx_in;
      status_ff  <= status_in;
      rdval_ff   <= rdval_in;
      fidx_ff    <= fidx_in;
      front_ff   <= front_in;
      back_ff    <= back_in;
   end

   // store conditions and head moves
   assign full     = (count_ff == CNT_W'(CAPACITY));
   assign empty    = (count_ff == '0);
   assign pos_bad  = (32'(pos_ff) >= 32'(count_ff));
   assign head_dec = (head_ff == '0) ? ADDR_W'(CAPACITY - 1) : head_ff - 1'b1;
   assign head_inc = (head_ff == ADDR_W'(CAPACITY - 1)) ? '0 : head_ff + 1'b1;
   // the shared comparator
   assign hit      = pend_ff && (rd_data == val_ff);

   // next state and outputs
   always_comb begin
      state_in   = state_ff;
      head_in    = head_ff;
      count_in   = count_ff;
      act_in     = act_ff;
      val_in     = val_ff;
      pos_in     = pos_ff;
      ri_in      = ri_ff;
      wi_in      = wi_ff;
      cmp_idx_in = cmp_idx_ff;
      pend_in    = pend_ff;
      status_in  = status_ff;
      rdval_in   = rdval_ff;
      fidx_in    = fidx_ff;
      front_in   = front_ff;
      back_in    = back_ff;
      wr_en      = 1'b0;
      wr_addr    = '0;
      wr_data    = val_ff;
      rd_en      = 1'b0;
      rd_addr    = '0;
      op_ready   = 1'b0;
      res_valid  = 1'b0;

      case (state_ff)
         S_IDLE: begin
            op_ready = 1'b1;
            if (op_valid) begin
               act_in   = op_action;
               val_in   = op_value;
               pos_in   = op_position;
               state_in = S_EXEC;
            end
         end

         // decide the operation and do the single-step ones
         S_EXEC: begin
            status_in = ST_OK;
            rdval_in  = '0;
            fidx_in   = '0;
            pend_in   = 1'b0;
            state_in  = S_FRONT;
            if (act_ff == ACT_PUSH_BACK || act_ff == ACT_PUSH_FRONT) begin
               if (full) begin
                  status_in = ST_FULL;
               end else begin
                  wr_en    = 1'b1;
                  count_in = count_ff + 1'b1;
                  if (act_ff == ACT_PUSH_BACK) begin
                     wr_addr = slot_of(head_ff, ADDR_W'(count_ff));
                  end else begin
                     wr_addr = head_dec;
                     head_in = head_dec;
                  end
               end
            end else if (empty) begin
               status_in = ST_EMPTY;
            end else begin
               case (act_ff)
                  ACT_POP_BACK: begin
                     count_in = count_ff - 1'b1;
                  end
                  ACT_POP_FRONT: begin
                     head_in  = head_inc;
                     count_in = count_ff - 1'b1;
                  end
                  ACT_FIND: begin
                     ri_in    = '0;
                     state_in = S_FIND;
                  end
                  ACT_READ_AT: begin
                     if (pos_bad) begin
                        status_in = ST_MISS;
                     end else begin
                        rd_en    = 1'b1;
                        rd_addr  = slot_of(head_ff, ADDR_W'(pos_ff));
                        state_in = S_READ;
                     end
                  end
                  ACT_DELETE_AT: begin
                     if (pos_bad) begin
                        status_in = ST_MISS;
                     end else begin
                        ri_in    = CNT_W'(pos_ff) + 1'b1;
                        state_in = S_DEL;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end

         // one read issued and one compare made per cycle
         S_FIND: begin
            if (hit) begin
               fidx_in  = cmp_idx_ff;
               pend_in  = 1'b0;
               state_in = S_FRONT;
            end else if (pend_ff && (CNT_W'(cmp_idx_ff) + 1'b1 == count_ff)) begin
               status_in = ST_MISS;
               pend_in   = 1'b0;
               state_in  = S_FRONT;
            end else begin
               rd_en      = 1'b1;
               rd_addr    = slot_of(head_ff, ri_ff[ADDR_W-1:0]);
               cmp_idx_in = ri_ff[ADDR_W-1:0];
               ri_in      = ri_ff + 1'b1;
               pend_in    = 1'b1;
            end
         end

         S_READ: begin
            rdval_in = rd_data;
            state_in = S_FRONT;
         end

         // close up: read element i+1 while writing the one read last cycle
         S_DEL: begin
            if (pend_ff) begin
               wr_en   = 1'b1;
               wr_addr = slot_of(head_ff, wi_ff);
               wr_data = rd_data;
            end
            if (ri_ff < count_ff) begin
               rd_en   = 1'b1;
               rd_addr = slot_of(head_ff, ri_ff[ADDR_W-1:0]);
               wi_in   = ri_ff[ADDR_W-1:0] - 1'b1;
               ri_in   = ri_ff + 1'b1;
               pend_in = 1'b1;
            end else begin
               pend_in = 1'b0;
               if (!pend_ff) begin
                  count_in = count_ff - 1'b1;
                  state_in = S_FRONT;
               end
            end
         end

         // front and back through the same read port
         S_FRONT: begin
            if (empty) begin
               front_in = '0;
               back_in  = '0;
               state_in = S_DONE;
            end else begin
               rd_en    = 1'b1;
               rd_addr  = head_ff;
               state_in = S_BACK;
            end
         end

         S_BACK: begin
            front_in = rd_data;
            rd_en    = 1'b1;
            rd_addr  = slot_of(head_ff, ADDR_W'(count_ff - 1'b1));
            state_in = S_BACK_CAP;
         end

         S_BACK_CAP: begin
            back_in  = rd_data;
            state_in = S_DONE;
         end

         S_DONE: begin
            res_valid = 1'b1;
            if (res_take) begin
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // result word
   always_comb begin
      res_word.status      = status_ff;
      res_word.read_value  = rdval_ff;
      res_word.found_index = IDX_W'(fidx_ff);
      res_word.length      = LEN_W'(count_ff);
      res_word.front_value = front_ff;
      res_word.back_value  = back_ff;
   end

   // element count stays within capacity
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("element count above capacity");

   // the store is never written while waiting for work
   a_no_idle_write: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE || state_ff == S_DONE) |-> !wr_en)
      else $error("store written outside an operation");

   // an accepted word always starts execution next cycle
   a_accept_exec: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE && op_valid) |=> state_ff == S_EXEC)
      else $error("accepted word not executed");

   // close-up reads stay inside the stored run
   a_del_read_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DEL && rd_en) |-> ri_ff < count_ff)
      else $error("close-up read beyond the last element");

   // find, read at a position and query leave the length unchanged
   a_len_step: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EXEC && (act_ff == ACT_FIND || act_ff == ACT_READ_AT
                              || act_ff == ACT_QUERY)) |=> $stable(count_ff))
      else $error("length changed by a non-modifying operation");

endmodule

@@ sv/searchable_deque_engine.sv @@
// top level: stream ports, sequencer and result output register
`timescale 1ns / 1ps

// Double-ended queue of up to 64 values of 64 bits with search, read and
// delete by position. Each request word carries one operation and yields
// exactly one response word with status, read value, found index, length,
// front and back. One operation is worked at a time: a word is taken in the
// idle state and executed, then front and back are read unless the store is
// empty afterwards, and the response is handed on; read at a position first
// reads its element. Find compares the elements in order up to the first
// match (all of them on a miss), and delete at position p moves each element
// behind p one place towards the front; both walk the single read port of
// the element store, which delivers one element per cycle. The response sits
// in an output register, so the next request is taken while it waits.
module searchable_deque_engine
   import sde_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   // action[2:0], value[66:3], position[72:67], zero pad
   input  logic [REQ_W-1:0]  req_tdata,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   // status[1:0], read_value[65:2], found_index[71:66], length[78:72],
   // front_value[142:79], back_value[206:143], zero pad
   output logic [RSP_W-1:0]  rsp_tdata
);

   action_type          op_action;
   logic [VALUE_W-1:0]  op_value;
   logic [POS_W-1:0]    op_position;
   logic                res_valid;
   logic                res_take;
   result_type          res_word;
   logic                rsp_valid_ff, rsp_valid_in;
   result_type          rsp_word_ff, rsp_word_in;

   // unpack the request word
   assign op_action   = action_type'(req_tdata[ACTION_W-1:0]);
   assign op_value    = req_tdata[ACTION_W +: VALUE_W];
   assign op_position = req_tdata[ACTION_W + VALUE_W +: POS_W];

   sde_seq u_seq (
      .clock       (clock),
      .reset       (reset),
      .op_valid    (req_tvalid),
      .op_action   (op_action),
      .op_value    (op_value),
      .op_position (op_position),
      .op_ready    (req_tready),
      .res_valid   (res_valid),
      .res_take    (res_take),
      .res_word    (res_word)
   );

   // output register load and drain
   assign res_take = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_word_in  = rsp_word_ff;
      if (res_take) begin
         rsp_valid_in = res_valid;
         if (res_valid) begin
            rsp_word_in = res_word;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_word_ff <= rsp_word_in;
   end

   // pack the response word
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_W'({rsp_word_ff.back_value,
                               rsp_word_ff.front_value,
                               rsp_word_ff.length,
                               rsp_word_ff.found_index,
                               rsp_word_ff.read_value,
                               rsp_word_ff.status});

endmodule

@@ tb/sv/tb_searchable_deque_engine.sv @@
// self-checking testbench for the searchable deque engine
`timescale 1ns / 1ps

module tb_searchable_deque_engine;
   import sde_pkg::*;

   localparam int ITEMS_PER_SEGMENT = 150;
   localparam int SEGMENTS          = 12;
   localparam int QUIET_LIMIT       = 4000;

   // response word layout, lowest bit first
   localparam int READ_LSB  = STATUS_W;
   localparam int IDX_LSB   = READ_LSB + VALUE_W;
   localparam int LEN_LSB   = IDX_LSB + IDX_W;
   localparam int FRONT_LSB = LEN_LSB + LEN_W;
   localparam int BACK_LSB  = FRONT_LSB + VALUE_W;

   typedef struct {
      status_type         status;
      logic [VALUE_W-1:0] read_value;
      logic [IDX_W-1:0]   found_index;
      logic [LEN_W-1:0]   length;
      logic [VALUE_W-1:0] front_value;
      logic [VALUE_W-1:0] back_value;
   } deque_result_type;

   // mirror of the deque contents in logical order, plus the responses it predicts
   class deque_shadow_type;
      logic [VALUE_W-1:0] contents[$];
      deque_result_type   awaited_results[$];
      int                 failures;

      function new();
         failures = 0;
      endfunction

      function int awaited_count();
         return awaited_results.size();
      endfunction

      // apply one accepted operation and queue the response it must produce
      function void note_request(action_type act, logic [VALUE_W-1:0] val,
                                 logic [POS_W-1:0] pos);
         deque_result_type r;
         int               i;
         r.status      = ST_OK;
         r.read_value  = '0;
         r.found_index = '0;
         if (act == ACT_PUSH_BACK || act == ACT_PUSH_FRONT) begin
            if (contents.size() >= CAPACITY) begin
               r.status = ST_FULL;
            end else if (act == ACT_PUSH_BACK) begin
               contents.push_back(val);
            end else begin
               contents.push_front(val);
            end
         end else if (contents.size() == 0) begin
            r.status = ST_EMPTY;
         end else begin
            case (act)
               ACT_POP_BACK: begin
                  void'(contents.pop_back());
               end
               ACT_POP_FRONT: begin
                  void'(contents.pop_front());
               end
               ACT_FIND: begin
                  // first match wins
                  r.status = ST_MISS;
                  for (i = 0; i < contents.size(); i++) begin
                     if (r.status == ST_MISS && contents[i] == val) begin
                        r.status      = ST_OK;
                        r.found_index = IDX_W'(i);
                     end
                  end
               end
               ACT_READ_AT: begin
                  if (pos >= contents.size()) r.status = ST_MISS;
                  else r.read_value = contents[pos];
               end
               ACT_DELETE_AT: begin
                  if (pos >= contents.size()) r.status = ST_MISS;
                  else contents.delete(pos);
               end
               default: begin
               end
            endcase
         end
         r.length      = LEN_W'(contents.size());
         r.front_value = (contents.size() == 0) ? '0 : contents[0];
         r.back_value  = (contents.size() == 0) ? '0 : contents[contents.size() - 1];
         awaited_results.push_back(r);
      endfunction

      function void compare_field(string field, logic [VALUE_W-1:0] want,
                                  logic [VALUE_W-1:0] got);
         if (got !== want) begin
            $error("%s mismatch: expected %0h, actual %0h", field, want, got);
            failures++;
         end
      endfunction

      // compare one accepted response word against the oldest prediction
      function void check_response(logic [RSP_W-1:0] word);
         deque_result_type want;
         if (awaited_results.size() == 0) begin
            $error("response word arrived with no request outstanding");
            failures++;
            return;
         end
         want = awaited_results.pop_front();
         compare_field("status", 64'(want.status), 64'(word[0 +: STATUS_W]));
         compare_field("read_value", want.read_value, word[READ_LSB +: VALUE_W]);
         compare_field("found_index", 64'(want.found_index), 64'(word[IDX_LSB +: IDX_W]));
         compare_field("length", 64'(want.length), 64'(word[LEN_LSB +: LEN_W]));
         compare_field("front_value", want.front_value, word[FRONT_LSB +: VALUE_W]);
         compare_field("back_value", want.back_value, word[BACK_LSB +: VALUE_W]);
      endfunction
   endclass

   logic             clock      = 1'b0;
   logic             reset      = 1'b1;
   logic             req_tvalid = 1'b0;
   logic             req_tready;
   logic [REQ_W-1:0] req_tdata  = '0;
   logic             rsp_tvalid;
   logic             rsp_tready = 1'b0;
   logic [RSP_W-1:0] rsp_tdata;

   deque_shadow_type shadow = new();

   // idling odds in percent, changed per segment
   int src_gap_pct    = 20;
   int sink_stall_pct = 20;

   searchable_deque_engine dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #10 clock = ~clock;

   // response word monitor
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         shadow.check_response(rsp_tdata);
      end
   end

   // receiver back-pressure in random bursts
   initial begin : sink_pacing
      int stall;
      forever begin
         @(posedge clock);
         if ($urandom_range(1, 100) <= sink_stall_pct) begin
            stall = $urandom_range(1, 11);
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
      end
   end

   // give up after a long stretch with no word moving on either side
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet = 0;
         else quiet++;
      end
      $display("Simulation FAILED");
      $finish;
   end

   // present one request word and hold it until taken
   task automatic send_request(input action_type act, input logic [VALUE_W-1:0] val,
                               input logic [POS_W-1:0] pos);
      logic [REQ_W-1:0] word;
      int               gap;
      word = '0;
      word[0 +: ACTION_W]               = act;
      word[ACTION_W +: VALUE_W]         = val;
      word[ACTION_W + VALUE_W +: POS_W] = pos;
      if ($urandom_range(1, 100) <= src_gap_pct) begin
         gap = $urandom_range(1, 11);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= word;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      shadow.note_request(act, val, pos);
   endtask

   // hold off the sender until every response is back
   task automatic wait_for_drain();
      req_tvalid <= 1'b0;
      while (shadow.awaited_count() != 0) @(posedge clock);
   endtask

   // values lean on extremes and a small pool so duplicates show up
   function automatic logic [VALUE_W-1:0] pick_value();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return '1;
         2, 3, 4: return VALUE_W'($urandom_range(0, 7));
         default: return {$urandom, $urandom};
      endcase
   endfunction

   // one random operation, pushes taken with the given odds
   task automatic send_random_item(input int push_pct);
      action_type         act;
      logic [VALUE_W-1:0] val;
      logic [POS_W-1:0]   pos;
      int                 len;
      len = shadow.contents.size();
      if ($urandom_range(1, 100) <= push_pct) begin
         act = $urandom_range(0, 1) ? ACT_PUSH_FRONT : ACT_PUSH_BACK;
      end else begin
         act = action_type'($urandom_range(ACT_POP_BACK, ACT_QUERY));
      end
      // searches mostly target a stored value
      if (act == ACT_FIND && len > 0 && $urandom_range(0, 9) < 6) begin
         val = shadow.contents[$urandom_range(0, len - 1)];
      end else begin
         val = pick_value();
      end
      if (len > 0 && $urandom_range(0, 9) < 8) pos = POS_W'($urandom_range(0, len - 1));
      else pos = POS_W'($urandom_range(0, 63));
      send_request(act, val, pos);
   endtask

   initial begin : stimulus
      int seg;
      int push_pct;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // every operation but the pushes on an empty deque
      send_request(ACT_QUERY, '0, '0);
      send_request(ACT_POP_BACK, '0, '0);
      send_request(ACT_POP_FRONT, '0, '0);
      send_request(ACT_FIND, '1, '0);
      send_request(ACT_READ_AT, '0, '0);
      send_request(ACT_DELETE_AT, '0, '1);
      // build a short deque from both ends
      send_request(ACT_PUSH_BACK, '1, '0);
      send_request(ACT_PUSH_FRONT, '0, '1);
      send_request(ACT_PUSH_BACK, 64'h8000_0000_0000_0001, '0);
      send_request(ACT_QUERY, '1, '1);
      // reads inside and past the end
      send_request(ACT_READ_AT, '0, 6'd0);
      send_request(ACT_READ_AT, '0, 6'd2);
      send_request(ACT_READ_AT, '0, 6'd3);
      send_request(ACT_READ_AT, '0, '1);
      // search hit, miss, and first of two matches
      send_request(ACT_FIND, '1, '0);
      send_request(ACT_FIND, 64'd5, '0);
      send_request(ACT_PUSH_BACK, '1, '0);
      send_request(ACT_FIND, '1, '0);
      // delete inside and out of range, then empty out
      send_request(ACT_DELETE_AT, '0, 6'd1);
      send_request(ACT_DELETE_AT, '0, '1);
      send_request(ACT_POP_FRONT, '0, '0);
      send_request(ACT_POP_BACK, '0, '0);
      send_request(ACT_POP_BACK, '0, '0);

      // fill to capacity, churn, then drain to empty, round and round
      for (seg = 0; seg < SEGMENTS; seg++) begin
         case (seg % 4)
            0: push_pct = 75;
            1: push_pct = 40;
            default: push_pct = 5;
         endcase
         if (seg == SEGMENTS - 1) begin
            src_gap_pct    = 0;
            sink_stall_pct = 0;
         end else begin
            src_gap_pct    = 20 * $urandom_range(0, 2);
            sink_stall_pct = 20 * $urandom_range(0, 2);
         end
         repeat (ITEMS_PER_SEGMENT) send_random_item(push_pct);
         if (seg == 4) wait_for_drain();
      end

      wait_for_drain();
      repeat (100) @(posedge clock);
      if (shadow.failures == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

@@ sim.f @@
sv/sde_pkg.sv
sv/sde_ram.sv
sv/sde_seq.sv
sv/searchable_deque_engine.sv
tb/sv/tb_searchable_deque_engine.sv
